[rtl/ucnt_pkg.sv]
// ----------------------------------------------------------------------------
// ucnt_pkg
// Shared types and constants for the utf-8 to utf-16 unit counter
// ----------------------------------------------------------------------------
package ucnt_pkg;

  localparam int unsigned DataW       = 8;
  localparam int unsigned TotalW      = 32;
  localparam int unsigned UnitsW      = 3;
  localparam int unsigned NeedW       = 2;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned QueueDepth  = 2;

  // byte class masks and patterns
  localparam logic [DataW-1:0] ContMask  = 8'hC0;
  localparam logic [DataW-1:0] ContPat   = 8'h80;
  localparam logic [DataW-1:0] Lead2Mask = 8'hE0;
  localparam logic [DataW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [DataW-1:0] Lead3Mask = 8'hF0;
  localparam logic [DataW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [DataW-1:0] Lead4Mask = 8'hF8;
  localparam logic [DataW-1:0] Lead4Pat  = 8'hF0;
  localparam logic [DataW-1:0] OvlMask   = 8'h1E;

  // work handed from the classifier to the accumulator
  typedef struct packed {
    logic [UnitsW-1:0] units;  // code units to add for this item
    logic              last;   // close the string after adding
  } ucnt_tok_t;

endpackage

[rtl/utf8_to_utf16_unit_counter_unit.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_unit_counter_unit
// Counts the utf-16 code units a utf-8 byte stream would need
// ----------------------------------------------------------------------------
// usage:
//   bytes enter on s_axis, one item per cycle while ready. tuser high means
//   tdata holds a byte; tuser low with tlast high closes a string without a
//   byte (an empty string or a bare end marker). tlast marks the end.
//   one item per string, the total, leaves on m_axis after the tlast item.
// throughput: one input item per cycle while s_axis_tready is high. the
//   classifier updates the open-sequence state and the accumulator adds to
//   the count once per item, so neither side loops.
// output: the closing item passes through the classifier-to-accumulator
//   queue, then its total is held in the output register.
// stalls: while a total waits unread, further bytes keep flowing into the
//   queue and the count of the next string; only the next closing item
//   waits, and once the queue fills, s_axis_tready drops.
// reset: clears the sequence state, the count, the queue and m_axis_tvalid.
// ----------------------------------------------------------------------------
module utf8_to_utf16_unit_counter_unit #(
  parameter int unsigned COUNT_WIDTH = ucnt_pkg::CountWidth,
  parameter int unsigned QUEUE_DEPTH = ucnt_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ucnt_pkg::DataW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] byte_present
  input  logic                          s_axis_tlast,   // last_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ucnt_pkg::TotalW-1:0]   m_axis_tdata    // [31:0] unit_total
);
  import ucnt_pkg::*;

  logic      in_accept;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  ucnt_tok_t front_tok;
  ucnt_tok_t q_tok;

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  ucnt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .data_byte_i    (s_axis_tdata),
    .byte_present_i (s_axis_tuser),
    .last_byte_i    (s_axis_tlast),
    .tok_o          (front_tok)
  );

  ucnt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_tok),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_tok)
  );

  ucnt_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (q_valid),
    .tok_i        (q_tok),
    .tok_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .unit_total_o (m_axis_tdata)
  );

endmodule

[rtl/ucnt_front.sv]
// ----------------------------------------------------------------------------
// ucnt_front
// Byte classifier: tracks the open utf-8 sequence, emits unit increments
// ----------------------------------------------------------------------------
module ucnt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [ucnt_pkg::DataW-1:0]   data_byte_i,
  input  logic                         byte_present_i,
  input  logic                         last_byte_i,
  output ucnt_pkg::ucnt_tok_t          tok_o
);
  import ucnt_pkg::*;

  logic [NeedW-1:0] need_q, need_d;
  logic [NeedW-1:0] gath_q, gath_d;
  logic             ovl_q, ovl_d;
  logic             four_q, four_d;

  always_comb begin
    logic [NeedW-1:0]  need_n;
    logic [NeedW-1:0]  gath_n;
    logic              ovl_n;
    logic              four_n;
    logic [UnitsW-1:0] units;

    need_n = need_q;
    gath_n = gath_q;
    ovl_n  = ovl_q;
    four_n = four_q;
    units  = '0;

    if (byte_present_i) begin
      if ((need_q != '0) && ((data_byte_i & ContMask) == ContPat)) begin
        gath_n = gath_q + NeedW'(1);
        need_n = need_q - NeedW'(1);
        if (need_q == NeedW'(1)) begin
          units  = (four_q || ovl_q) ? UnitsW'(2) : UnitsW'(1);
          need_n = '0;
          gath_n = '0;
          ovl_n  = 1'b0;
          four_n = 1'b0;
        end
      end else begin
        // broken sequence: gathered bytes count one each, then classify afresh
        if (need_q != '0) begin
          units  = UnitsW'(gath_q);
          need_n = '0;
          gath_n = '0;
          ovl_n  = 1'b0;
          four_n = 1'b0;
        end
        priority if (data_byte_i < ContPat) begin
          units = units + UnitsW'(1);
        end else if ((data_byte_i & Lead2Mask) == Lead2Pat) begin
          need_n = NeedW'(1);
          gath_n = NeedW'(1);
          ovl_n  = (data_byte_i & OvlMask) == '0;
        end else if ((data_byte_i & Lead3Mask) == Lead3Pat) begin
          need_n = NeedW'(2);
          gath_n = NeedW'(1);
        end else if ((data_byte_i & Lead4Mask) == Lead4Pat) begin
          need_n = NeedW'(3);
          gath_n = NeedW'(1);
          four_n = 1'b1;
        end else begin
          units = units + UnitsW'(1);
        end
      end
    end

    // end of string flushes whatever is still open
    if (last_byte_i) begin
      units  = units + UnitsW'(gath_n);
      need_n = '0;
      gath_n = '0;
      ovl_n  = 1'b0;
      four_n = 1'b0;
    end

    need_d = need_n;
    gath_d = gath_n;
    ovl_d  = ovl_n;
    four_d = four_n;
    tok_o.units = units;
    tok_o.last  = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= '0;
      gath_q <= '0;
      ovl_q  <= 1'b0;
      four_q <= 1'b0;
    end else if (accept_i) begin
      need_q <= need_d;
      gath_q <= gath_d;
      ovl_q  <= ovl_d;
      four_q <= four_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> need_q == '0 && gath_q == '0)
    else $error("sequence state not cleared at end of string");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q == '0 |-> gath_q == '0 && !ovl_q && !four_q)
    else $error("stale sequence state with nothing open");

  a_four_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    four_q |-> (3'(need_q) + 3'(gath_q)) == 3'd4 && !ovl_q)
    else $error("four-byte sequence bookkeeping broken");

endmodule

[rtl/ucnt_fifo.sv]
// ----------------------------------------------------------------------------
// ucnt_fifo
// Small queue between classifier and accumulator
// ----------------------------------------------------------------------------
module ucnt_fifo #(
  parameter int unsigned DEPTH = ucnt_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ucnt_pkg::ucnt_tok_t  push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output ucnt_pkg::ucnt_tok_t  pop_data_o
);
  import ucnt_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ucnt_tok_t        mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = cnt_q == FullCnt;
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/ucnt_back.sv]
// ----------------------------------------------------------------------------
// ucnt_back
// Accumulator: saturating unit count and registered total output
// ----------------------------------------------------------------------------
module ucnt_back #(
  parameter int unsigned COUNT_WIDTH = ucnt_pkg::CountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tok_valid_i,
  input  ucnt_pkg::ucnt_tok_t           tok_i,
  output logic                          tok_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ucnt_pkg::TotalW-1:0]   unit_total_o
);
  import ucnt_pkg::*;

  logic [COUNT_WIDTH-1:0] run_q, run_d;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat;
  logic                   out_valid_q, out_valid_d;
  logic [TotalW-1:0]      total_q, total_d;

  assign sum = {1'b0, run_q} + (COUNT_WIDTH + 1)'(tok_i.units);
  assign sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

  // a closing item waits only while the previous total is still unread
  assign tok_pop_o = tok_valid_i && (!tok_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    run_d       = run_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (tok_pop_o) begin
      if (tok_i.last) begin
        run_d       = '0;
        total_d     = TotalW'(sat);
        out_valid_d = 1'b1;
      end else begin
        run_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

  assign out_valid_o  = out_valid_q;
  assign unit_total_o = total_q;

  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && tok_i.last |=> run_q == '0 && out_valid_q)
    else $error("count not restarted after end of string");

  a_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && !tok_i.last |=> run_q >= $past(run_q))
    else $error("running count went down");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && tok_valid_i && tok_i.last |-> !tok_pop_o)
    else $error("pending total overwritten");

endmodule
